// ===== rtl/mmbp_pkg.sv =====
// package for the multi-mode branch predictor
// field widths, mode and register codes, reset values; no dependencies
package mmbp_pkg;

   localparam int DEF_MAX_INDEX_BITS   = 8;
   localparam int DEF_MAX_HISTORY_BITS = 6;
   localparam int DEF_MAX_COUNTER_BITS = 4;

   localparam int PC_W       = 64;
   localparam int CTR_OUT_W  = 4;
   localparam int MODE_W     = 2;
   localparam int CB_W       = 3;
   localparam int HB_W       = 3;
   localparam int IB_W       = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [MODE_W-1:0] MODE_BIMODAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GSHARE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOCAL     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TWO_LEVEL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNTER_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HISTORY_BITS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INDEX_BITS   = 2'd3;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam int RST_COUNTER_BITS = 2;
   localparam int RST_HISTORY_BITS = 6;
   localparam int RST_INDEX_BITS   = 8;

endpackage

// ===== rtl/mmbp_if.sv =====
// request and response channel interfaces of the branch predictor
// depends on mmbp_pkg
interface mmbp_req_if import mmbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            operation;
   logic [PC_W-1:0] pc;
   logic            taken;

   modport source (output valid, operation, pc, taken, input ready);
   modport sink (input valid, operation, pc, taken, output ready);
endinterface

interface mmbp_rsp_if import mmbp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 predict_taken;
   logic [CTR_OUT_W-1:0] counter_value;

   modport source (output valid, predict_taken, counter_value, input ready);
   modport sink (input valid, predict_taken, counter_value, output ready);
endinterface

// ===== rtl/multi_mode_branch_predictor_core.sv =====
// multi-mode branch predictor: bimodal, gshare, local and two-level modes
// depends on mmbp_pkg and the channel interfaces in mmbp_if.sv
//
// usage
//   req_ch carries predict and update items; an item transfers when valid and
//   ready are both high. a predict returns one transfer on rsp_ch with the
//   direction and the counter consulted; an update returns nothing.
//   csr_we/csr_index/csr_wdata write the mode and width registers; any write
//   clears the counter valid flags and all histories.
//   on the transfer the local history memory is read into a register; in the
//   ST_HIST state the counter memory is read, and in ST_CTR the counter is
//   modified and written back while the result register loads. ready returns
//   in the cycle after the writeback, so no new item is taken until the last
//   one is through; the two chained memory reads set this.
//   a predict result sits in an output register; if rsp_ch stalls with a
//   result still held, the next predict waits in its last cycle until the
//   held result transfers, while the request side keeps working up to it.
//   after reset and after every register write a clearing sweep runs over
//   all 2^(MAX_INDEX_BITS+MAX_HISTORY_BITS) counter memory entries (16384 by
//   default); req_ch.ready stays low during it.
module multi_mode_branch_predictor_core
   import mmbp_pkg::*;
#(
   parameter int MAX_INDEX_BITS   = DEF_MAX_INDEX_BITS,
   parameter int MAX_HISTORY_BITS = DEF_MAX_HISTORY_BITS,
   parameter int MAX_COUNTER_BITS = DEF_MAX_COUNTER_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   mmbp_req_if.sink              req_ch,
   mmbp_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MI = MAX_INDEX_BITS;
   localparam int MH = MAX_HISTORY_BITS;
   localparam int MC = MAX_COUNTER_BITS;
   localparam int SW = MI + MH;
   localparam int CTR_DEPTH  = 1 << SW;
   localparam int HIST_DEPTH = 1 << MI;

   localparam int RST_CB = (RST_COUNTER_BITS > MC) ? MC : RST_COUNTER_BITS;
   localparam int RST_HB = (RST_HISTORY_BITS > MH) ? MH : RST_HISTORY_BITS;
   localparam int RST_IB = (RST_INDEX_BITS > MI) ? MI : RST_INDEX_BITS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_HIST  = 2'd2;
   localparam logic [1:0] ST_CTR   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SW-1:0]     clr_addr_ff, clr_addr_in;
   logic [MODE_W-1:0] cfg_mode_ff, cfg_mode_in;
   logic [CB_W-1:0]   cfg_cb_ff, cfg_cb_in;
   logic [HB_W-1:0]   cfg_hb_ff, cfg_hb_in;
   logic [IB_W-1:0]   cfg_ib_ff, cfg_ib_in;
   logic [MH-1:0]     ghist_ff, ghist_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              op_ff;
   logic              taken_ff;
   logic [MI-1:0]     pc_lo_ff;
   logic [MI-1:0]     entry_ff;
   logic [SW-1:0]     slot_ff;
   logic              rsp_taken_ff;
   logic [CTR_OUT_W-1:0] rsp_value_ff;

   logic [MC:0]       ctr_mem [CTR_DEPTH];
   logic [MH-1:0]     hist_mem [HIST_DEPTH];
   logic [MC:0]       ctr_rdata_ff;
   logic [MH-1:0]     hist_rdata_ff;

   logic          cfg_hit;
   logic          req_xfer;
   logic          advance;
   logic [MI-1:0] imask_mi;
   logic [SW-1:0] imask_sw;
   logic [MH-1:0] hmask;
   logic [MH-1:0] lhist;
   logic [SW-1:0] slot;
   logic [MC-1:0] half;
   logic [MC-1:0] top;
   logic [MC-1:0] ctr_cur;
   logic [MC-1:0] ctr_upd;
   logic [MC-1:0] ctr_wval;
   logic [MH-1:0] hist_shift;
   logic          hist_we;
   logic          ctr_we;
   logic [SW-1:0] ctr_waddr;
   logic [MC:0]   ctr_wdata;
   logic [MI-1:0] hist_waddr;
   logic [MH-1:0] hist_wdata;

   assign cfg_hit  = csr_we;
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_we;
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign imask_mi = ~({MI{1'b1}} << cfg_ib_ff);
   assign imask_sw = ~({SW{1'b1}} << cfg_ib_ff);
   assign hmask    = ~({MH{1'b1}} << cfg_hb_ff);
   assign half     = MC'(1) << (cfg_cb_ff - CB_W'(1));
   assign top      = ~({MC{1'b1}} << cfg_cb_ff);

   // slot selection per mode from the entry index, the global history or the history read
   assign lhist = hist_rdata_ff & hmask;
   always_comb begin
      case (cfg_mode_ff)
         MODE_BIMODAL:   slot = SW'(entry_ff);
         MODE_GSHARE:    slot = (SW'(pc_lo_ff) ^ SW'(ghist_ff & hmask)) & imask_sw;
         MODE_LOCAL:     slot = (SW'(entry_ff) << cfg_hb_ff) | SW'(lhist);
         MODE_TWO_LEVEL: slot = SW'(lhist);
         default:        slot = SW'(entry_ff);
      endcase
   end

   // counter modify
   assign ctr_cur = ctr_rdata_ff[MC] ? ctr_rdata_ff[MC-1:0] : half;
   always_comb begin
      if (taken_ff) begin
         ctr_upd = (ctr_cur < top) ? ctr_cur + MC'(1) : ctr_cur;
      end else begin
         ctr_upd = (ctr_cur != '0) ? ctr_cur - MC'(1) : ctr_cur;
      end
   end
   assign ctr_wval = (op_ff == OP_PREDICT) ? ctr_cur : ctr_upd;
   assign hist_shift = ((hist_rdata_ff << 1) | MH'(taken_ff)) & hmask;

   assign advance = (state_ff == ST_CTR) &&
                    ((op_ff == OP_UPDATE) || !rsp_valid_ff || rsp_ch.ready);

   // memory write ports, shared by the clearing sweep and the writeback
   always_comb begin
      ctr_we     = 1'b0;
      ctr_waddr  = slot_ff;
      ctr_wdata  = {1'b1, ctr_wval};
      hist_we    = 1'b0;
      hist_waddr = entry_ff;
      hist_wdata = hist_shift;
      if (state_ff == ST_CLEAR) begin
         ctr_we     = 1'b1;
         ctr_waddr  = clr_addr_ff;
         ctr_wdata  = '0;
         hist_we    = 1'b1;
         hist_waddr = clr_addr_ff[MI-1:0];
         hist_wdata = '0;
      end else if (advance) begin
         ctr_we  = 1'b1;
         hist_we = (op_ff == OP_UPDATE) &&
                   ((cfg_mode_ff == MODE_LOCAL) || (cfg_mode_ff == MODE_TWO_LEVEL));
      end
   end

   always_ff @(posedge clock) begin
      if (ctr_we) begin
         ctr_mem[ctr_waddr] <= ctr_wdata;
      end
      if (state_ff == ST_HIST) begin
         ctr_rdata_ff <= ctr_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (req_xfer) begin
         hist_rdata_ff <= hist_mem[req_ch.pc[MI-1:0] & imask_mi];
      end
   end

   // control next state
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cfg_mode_in = cfg_mode_ff;
      cfg_cb_in   = cfg_cb_ff;
      cfg_hb_in   = cfg_hb_ff;
      cfg_ib_in   = cfg_ib_ff;
      ghist_in    = ghist_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + SW'(1);
            if (clr_addr_ff == {SW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_HIST;
            end
         end
         ST_HIST: state_in = ST_CTR;
         ST_CTR: begin
            if (advance) begin
               state_in = ST_IDLE;
               if ((op_ff == OP_UPDATE) && (cfg_mode_ff == MODE_GSHARE)) begin
                  ghist_in = ((ghist_ff << 1) | MH'(taken_ff)) & hmask;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (cfg_hit) begin
         state_in    = ST_CLEAR;
         clr_addr_in = '0;
         ghist_in    = '0;
         case (csr_index)
            REG_MODE: cfg_mode_in = csr_wdata[MODE_W-1:0];
            REG_COUNTER_BITS: begin
               if (csr_wdata[CB_W-1:0] == '0) begin
                  cfg_cb_in = CB_W'(1);
               end else if (int'(csr_wdata[CB_W-1:0]) > MC) begin
                  cfg_cb_in = CB_W'(MC);
               end else begin
                  cfg_cb_in = csr_wdata[CB_W-1:0];
               end
            end
            REG_HISTORY_BITS: begin
               if (csr_wdata[HB_W-1:0] == '0) begin
                  cfg_hb_in = HB_W'(1);
               end else if (int'(csr_wdata[HB_W-1:0]) > MH) begin
                  cfg_hb_in = HB_W'(MH);
               end else begin
                  cfg_hb_in = csr_wdata[HB_W-1:0];
               end
            end
            REG_INDEX_BITS: begin
               if (csr_wdata[IB_W-1:0] == '0) begin
                  cfg_ib_in = IB_W'(1);
               end else if (int'(csr_wdata[IB_W-1:0]) > MI) begin
                  cfg_ib_in = IB_W'(MI);
               end else begin
                  cfg_ib_in = csr_wdata[IB_W-1:0];
               end
            end
            default: cfg_mode_in = cfg_mode_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && (op_ff == OP_PREDICT)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         cfg_mode_ff  <= MODE_BIMODAL;
         cfg_cb_ff    <= CB_W'(RST_CB);
         cfg_hb_ff    <= HB_W'(RST_HB);
         cfg_ib_ff    <= IB_W'(RST_IB);
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cfg_mode_ff  <= cfg_mode_in;
         cfg_cb_ff    <= cfg_cb_in;
         cfg_hb_ff    <= cfg_hb_in;
         cfg_ib_ff    <= cfg_ib_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload and result registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_ch.operation;
         taken_ff <= req_ch.taken;
         pc_lo_ff <= req_ch.pc[MI-1:0];
         entry_ff <= req_ch.pc[MI-1:0] & imask_mi;
      end
      if (state_ff == ST_HIST) begin
         slot_ff <= slot;
      end
      if (advance && (op_ff == OP_PREDICT)) begin
         rsp_taken_ff <= (ctr_cur >= half);
         rsp_value_ff <= CTR_OUT_W'(ctr_cur);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.predict_taken = rsp_taken_ff;
   assign rsp_ch.counter_value = rsp_value_ff;

   a_rsp_from_ctr: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_CTR))
      else $error("response raised outside the writeback cycle");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("request accepted during clearing sweep");

   a_ctr_saturates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CTR) |-> (ctr_wval <= top))
      else $error("counter writeback above saturation");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("held result overwritten");

endmodule
